// File: src/aff_pkg.sv
// ----------------------------------------------------------------------------
// aff_pkg
// Shared constants, types and helpers of the chunk frustum culling block.
// ----------------------------------------------------------------------------
package aff_pkg;

    // item opcodes
    localparam logic OP_TEST = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // plane store
    localparam int PLANE_COUNT = 6;
    localparam int PIDX_W      = 3;

    // field widths
    localparam int NRM_W = 16;   // Q1.14 normal component
    localparam int OFS_W = 32;   // Q16.16 plane offset
    localparam int CRD_W = 32;   // Q16.16 chunk corner

    // datapath widths
    localparam int CTR_W      = CRD_W + 1;       // corner plus half edge (half < 2^31)
    localparam int PROD_W     = CTR_W + NRM_W;   // Q.30 product
    localparam int DIST_W     = PROD_W + 3;      // sum of three products and offset
    localparam int SUMABS_W   = NRM_W + 1;       // |nx|+|ny|+|nz| <= 3*2^15
    localparam int HALF_SHIFT = 15;              // edge/2 in Q16.16 = edge << 15
    localparam int OFS_SHIFT  = 14;              // Q16.16 -> Q.30

    localparam int DEF_CHUNK_EDGE = 16;

    // APB register file
    localparam int  APB_ADDR_W      = 3;
    localparam int  APB_DATA_W      = 32;
    localparam logic REG_REJECT_SIDE = 1'b0;     // word index of reject_side

    // radius width for a given chunk edge
    function automatic int f_rad_w(input int edge_len);
        f_rad_w = SUMABS_W + $clog2(edge_len + 1) + HALF_SHIFT;
    endfunction

    // stage enables handed to the plane lanes
    typedef struct packed {
        logic en_s2;
        logic en_s3;
        logic en_s4;
    } t_pipe_ctl;

endpackage

// File: src/aff_plane_store.sv
// ----------------------------------------------------------------------------
// aff_plane_store
// Six plane slots: normal, offset and precomputed projected radius.
// ----------------------------------------------------------------------------
module aff_plane_store
    import aff_pkg::*;
#(
    parameter int CHUNK_EDGE = DEF_CHUNK_EDGE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [PIDX_W-1:0]                 i_wr_index,
    input  logic signed [NRM_W-1:0]           i_normal_x,
    input  logic signed [NRM_W-1:0]           i_normal_y,
    input  logic signed [NRM_W-1:0]           i_normal_z,
    input  logic signed [OFS_W-1:0]           i_offset,
    output logic signed [NRM_W-1:0]           o_nx     [PLANE_COUNT],
    output logic signed [NRM_W-1:0]           o_ny     [PLANE_COUNT],
    output logic signed [NRM_W-1:0]           o_nz     [PLANE_COUNT],
    output logic signed [OFS_W-1:0]           o_offset [PLANE_COUNT],
    output logic [f_rad_w(CHUNK_EDGE)-1:0]    o_radius [PLANE_COUNT]
);

    localparam int RAD_W   = f_rad_w(CHUNK_EDGE);
    localparam int UNITS_W = RAD_W - HALF_SHIFT;

    logic signed [NRM_W-1:0]  r_nx     [PLANE_COUNT];
    logic signed [NRM_W-1:0]  r_ny     [PLANE_COUNT];
    logic signed [NRM_W-1:0]  r_nz     [PLANE_COUNT];
    logic signed [OFS_W-1:0]  r_offset [PLANE_COUNT];
    logic [RAD_W-1:0]         r_radius [PLANE_COUNT];

    logic [NRM_W-1:0]    w_ax;
    logic [NRM_W-1:0]    w_ay;
    logic [NRM_W-1:0]    w_az;
    logic [SUMABS_W-1:0] w_sumabs;
    logic [UNITS_W-1:0]  w_units;
    logic [RAD_W-1:0]    w_radius;

    // |n| of -2^15 is 2^15, still fits unsigned 16 bits
    assign w_ax     = i_normal_x[NRM_W-1] ? NRM_W'(-i_normal_x) : NRM_W'(i_normal_x);
    assign w_ay     = i_normal_y[NRM_W-1] ? NRM_W'(-i_normal_y) : NRM_W'(i_normal_y);
    assign w_az     = i_normal_z[NRM_W-1] ? NRM_W'(-i_normal_z) : NRM_W'(i_normal_z);
    assign w_sumabs = SUMABS_W'(w_ax) + SUMABS_W'(w_ay) + SUMABS_W'(w_az);
    assign w_units  = UNITS_W'(w_sumabs) * UNITS_W'(CHUNK_EDGE);
    assign w_radius = {w_units, {HALF_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            if (!i_rst_n) begin
                r_nx[i]     <= '0;
                r_ny[i]     <= '0;
                r_nz[i]     <= '0;
                r_offset[i] <= '0;
                r_radius[i] <= '0;
            end else if (i_wr_en && (i_wr_index == PIDX_W'(i))) begin
                r_nx[i]     <= i_normal_x;
                r_ny[i]     <= i_normal_y;
                r_nz[i]     <= i_normal_z;
                r_offset[i] <= i_offset;
                r_radius[i] <= w_radius;
            end
        end
    end

    assign o_nx     = r_nx;
    assign o_ny     = r_ny;
    assign o_nz     = r_nz;
    assign o_offset = r_offset;
    assign o_radius = r_radius;

endmodule

// File: src/aff_plane_lane.sv
// ----------------------------------------------------------------------------
// aff_plane_lane
// One plane test: products, partial sums, distance, reject decision.
// ----------------------------------------------------------------------------
module aff_plane_lane
    import aff_pkg::*;
#(
    parameter int CHUNK_EDGE = DEF_CHUNK_EDGE
) (
    input  logic                            i_clk,
    input  t_pipe_ctl                       i_ctl,
    input  logic signed [CTR_W-1:0]         i_cx,
    input  logic signed [CTR_W-1:0]         i_cy,
    input  logic signed [CTR_W-1:0]         i_cz,
    input  logic signed [NRM_W-1:0]         i_nx,
    input  logic signed [NRM_W-1:0]         i_ny,
    input  logic signed [NRM_W-1:0]         i_nz,
    input  logic signed [OFS_W-1:0]         i_offset,
    input  logic [f_rad_w(CHUNK_EDGE)-1:0]  i_radius,
    input  logic                            i_reject_side,
    output logic                            o_reject
);

    localparam int RAD_W = f_rad_w(CHUNK_EDGE);

    // stage 2: products
    logic signed [PROD_W-1:0] w_px, w_py, w_pz;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [OFS_W-1:0]  r_ofs2;
    logic [RAD_W-1:0]         r_rad2;

    // stage 3: partial sums
    logic signed [DIST_W-1:0] w_ofs_q30;
    logic signed [DIST_W-1:0] r_sum_a, r_sum_b;
    logic [RAD_W-1:0]         r_rad3;

    // stage 4: distance
    logic signed [DIST_W-1:0] r_dist;
    logic [RAD_W-1:0]         r_rad4;

    logic signed [DIST_W-1:0] w_rad_s;
    logic signed [DIST_W-1:0] w_test;

    assign w_px = i_cx * i_nx;
    assign w_py = i_cy * i_ny;
    assign w_pz = i_cz * i_nz;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_px   <= w_px;
            r_py   <= w_py;
            r_pz   <= w_pz;
            r_ofs2 <= i_offset;
            r_rad2 <= i_radius;
        end
    end

    assign w_ofs_q30 = {{(DIST_W-OFS_W-OFS_SHIFT){r_ofs2[OFS_W-1]}}, r_ofs2,
                        {OFS_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s3) begin
            r_sum_a <= DIST_W'(r_px) + DIST_W'(r_py);
            r_sum_b <= DIST_W'(r_pz) - w_ofs_q30;
            r_rad3  <= r_rad2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s4) begin
            r_dist <= r_sum_a + r_sum_b;
            r_rad4 <= r_rad3;
        end
    end

    // positive side: dist > rad  <=> rad - dist < 0
    // negative side: dist < -rad <=> dist + rad < 0
    assign w_rad_s  = signed'(DIST_W'(r_rad4));
    assign w_test   = i_reject_side ? (w_rad_s - r_dist) : (r_dist + w_rad_s);
    assign o_reject = w_test[DIST_W-1];

endmodule

// File: src/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Culls cubic chunks against six stored frustum planes, one item per cycle.
// ----------------------------------------------------------------------------
// Items arrive on the input channel. A load transaction (opcode 1) writes one
// of six plane slots (index 0..5; 6 and 7 are dropped) and gives no result.
// A test transaction (opcode 0) gives exactly one result transaction with
// o_visible = 0 when some plane sees the chunk box entirely on the rejecting
// side (reject_side register: 0 = negative side, 1 = positive side). The block
// takes one transaction per clock while the input is not stalled. A test
// passes through the input register (box center), product register, partial
// sum register, distance register and result register.
// The six planes are tested side by side, each with its own three
// multipliers, so that sustained rate is one test per cycle while the output
// does not stall. A load is seen by every test accepted after it and by none
// before it. Planes reset to zero, and a zero plane never rejects. Each stage
// holds its item while the next one is full and cannot advance, so the input
// is stalled only when all five stages are occupied.
// reject_side sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module aabb_frustum_cull
    import aff_pkg::*;
#(
    parameter int CHUNK_EDGE = DEF_CHUNK_EDGE
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_opcode,
    input  logic [PIDX_W-1:0]       i_plane_index,
    input  logic signed [NRM_W-1:0] i_normal_x,
    input  logic signed [NRM_W-1:0] i_normal_y,
    input  logic signed [NRM_W-1:0] i_normal_z,
    input  logic signed [OFS_W-1:0] i_plane_offset,
    input  logic signed [CRD_W-1:0] i_chunk_x,
    input  logic signed [CRD_W-1:0] i_chunk_y,
    input  logic signed [CRD_W-1:0] i_chunk_z,

    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_visible,

    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int RAD_W = f_rad_w(CHUNK_EDGE);
    localparam int HALF  = CHUNK_EDGE << HALF_SHIFT;   // edge/2 in Q16.16

    // ---------------- configuration ----------------
    logic r_reject_side;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reject_side <= 1'b0;
        end else if (w_cfg_wr && (paddr[2] == REG_REJECT_SIDE)) begin
            r_reject_side <= pwdata[0];
        end
    end

    // word address only; byte lanes ignored
    assign prdata = (paddr[2] == REG_REJECT_SIDE) ? APB_DATA_W'(r_reject_side) : '0;

    // ---------------- pipeline control ----------------
    logic      r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_out_valid;
    logic      w_en_s1, w_en_out;
    logic      w_accept;
    t_pipe_ctl w_ctl;

    // a stage advances when it is empty or its successor advances
    assign w_en_out     = !r_out_valid || !i_out_stall;
    assign w_ctl.en_s4  = !r_s4_valid  || w_en_out;
    assign w_ctl.en_s3  = !r_s3_valid  || w_ctl.en_s4;
    assign w_ctl.en_s2  = !r_s2_valid  || w_ctl.en_s3;
    assign w_en_s1      = !r_s1_valid  || w_ctl.en_s2;

    assign o_in_stall = !w_en_s1;
    assign w_accept   = i_in_valid && w_en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en_s1)     r_s1_valid  <= w_accept && (i_opcode == OP_TEST);
            if (w_ctl.en_s2) r_s2_valid  <= r_s1_valid;
            if (w_ctl.en_s3) r_s3_valid  <= r_s2_valid;
            if (w_ctl.en_s4) r_s4_valid  <= r_s3_valid;
            if (w_en_out)    r_out_valid <= r_s4_valid;
        end
    end

    // ---------------- stage 1: box center ----------------
    logic signed [CTR_W-1:0] r_s1_cx, r_s1_cy, r_s1_cz;

    always_ff @(posedge i_clk) begin
        if (w_en_s1) begin
            r_s1_cx <= CTR_W'(i_chunk_x) + CTR_W'(HALF);
            r_s1_cy <= CTR_W'(i_chunk_y) + CTR_W'(HALF);
            r_s1_cz <= CTR_W'(i_chunk_z) + CTR_W'(HALF);
        end
    end

    // ---------------- plane store ----------------
    logic                    w_load;
    logic signed [NRM_W-1:0] w_nx     [PLANE_COUNT];
    logic signed [NRM_W-1:0] w_ny     [PLANE_COUNT];
    logic signed [NRM_W-1:0] w_nz     [PLANE_COUNT];
    logic signed [OFS_W-1:0] w_offset [PLANE_COUNT];
    logic [RAD_W-1:0]        w_radius [PLANE_COUNT];

    // out-of-range slots are dropped
    assign w_load = w_accept && (i_opcode == OP_LOAD)
                    && (i_plane_index < PIDX_W'(PLANE_COUNT));

    aff_plane_store #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_load),
        .i_wr_index (i_plane_index),
        .i_normal_x (i_normal_x),
        .i_normal_y (i_normal_y),
        .i_normal_z (i_normal_z),
        .i_offset   (i_plane_offset),
        .o_nx       (w_nx),
        .o_ny       (w_ny),
        .o_nz       (w_nz),
        .o_offset   (w_offset),
        .o_radius   (w_radius)
    );

    // ---------------- plane lanes, stages 2..4 ----------------
    logic [PLANE_COUNT-1:0] w_reject;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
        aff_plane_lane #(
            .CHUNK_EDGE (CHUNK_EDGE)
        ) u_lane (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_cx          (r_s1_cx),
            .i_cy          (r_s1_cy),
            .i_cz          (r_s1_cz),
            .i_nx          (w_nx[p]),
            .i_ny          (w_ny[p]),
            .i_nz          (w_nz[p]),
            .i_offset      (w_offset[p]),
            .i_radius      (w_radius[p]),
            .i_reject_side (r_reject_side),
            .o_reject      (w_reject[p])
        );
    end

    // ---------------- result register ----------------
    logic r_visible;
    logic n_visible;

    assign n_visible = ~|w_reject;

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_visible <= n_visible;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

    // ---------------- assertions ----------------
    // input backs up only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_s4_valid
                        && r_out_valid))
        else $error("input stalled with a free stage");

    // a load never enters the test pipeline
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_LOAD)) |=> !r_s1_valid)
        else $error("load transaction entered the pipeline");

    // a result appears only from a filled distance stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s4_valid))
        else $error("result without a source item");

    // a test accepted into an empty stage 1 occupies it next cycle
    a_test_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_TEST)) |=> r_s1_valid)
        else $error("accepted test lost at stage 1");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunk frustum culling block.
// ----------------------------------------------------------------------------
// Drives plane loads and chunk tests through the input channel and checks
// each o_visible against a local plane store and box classifier kept in step
// with every accepted transaction. Covers both reject_side settings, field
// extremes, dropped loads to slots 6 and 7, zero planes and exact boundary
// touches. Random traffic is mostly well-formed six-plane boxes followed by
// chunk tests around them, with some raw full-range noise mixed in.
// ----------------------------------------------------------------------------
module tb_top
    import aff_pkg::*;
();

    localparam int CHUNK_EDGE     = DEF_CHUNK_EDGE;
    localparam longint HALF_Q16   = longint'(CHUNK_EDGE) * 32768;   // edge/2 in Q16.16
    localparam longint Q_ONE      = 16384;                          // 1.0 in Q1.14
    localparam int PHASE_ITEMS    = 450;
    localparam int DRAIN_CYCLES   = 16;     // pipeline is five deep, keep margin
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [APB_ADDR_W-1:0] REJECT_SIDE_ADDR = APB_ADDR_W'(4 * REG_REJECT_SIDE);

    // one input transaction, fields as raw bits
    typedef struct packed {
        logic              op;
        logic [PIDX_W-1:0] pidx;
        logic [NRM_W-1:0]  nx;
        logic [NRM_W-1:0]  ny;
        logic [NRM_W-1:0]  nz;
        logic [OFS_W-1:0]  ofs;
        logic [CRD_W-1:0]  cx;
        logic [CRD_W-1:0]  cy;
        logic [CRD_W-1:0]  cz;
    } t_cull_req;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    // DUT inputs, all known from time zero
    logic              in_valid     = 1'b0;
    logic              opcode       = OP_TEST;
    logic [PIDX_W-1:0] plane_index  = '0;
    logic [NRM_W-1:0]  normal_x     = '0;
    logic [NRM_W-1:0]  normal_y     = '0;
    logic [NRM_W-1:0]  normal_z     = '0;
    logic [OFS_W-1:0]  plane_offset = '0;
    logic [CRD_W-1:0]  chunk_x      = '0;
    logic [CRD_W-1:0]  chunk_y      = '0;
    logic [CRD_W-1:0]  chunk_z      = '0;
    logic              out_stall    = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;

    // DUT outputs
    logic                  in_stall;
    logic                  out_valid;
    logic                  visible;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    aabb_frustum_cull #(
        .CHUNK_EDGE(CHUNK_EDGE)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_opcode       (opcode),
        .i_plane_index  (plane_index),
        .i_normal_x     (normal_x),
        .i_normal_y     (normal_y),
        .i_normal_z     (normal_z),
        .i_plane_offset (plane_offset),
        .i_chunk_x      (chunk_x),
        .i_chunk_y      (chunk_y),
        .i_chunk_z      (chunk_z),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_visible      (visible),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow state: plane store and reject side as the block should hold them
    // ------------------------------------------------------------------------
    logic [NRM_W-1:0] pl_nx  [PLANE_COUNT];
    logic [NRM_W-1:0] pl_ny  [PLANE_COUNT];
    logic [NRM_W-1:0] pl_nz  [PLANE_COUNT];
    logic [OFS_W-1:0] pl_ofs [PLANE_COUNT];
    logic             reject_pos = 1'b0;   // reject_side register copy

    t_cull_req cull_req_q[$];        // transactions waiting for the driver
    logic      exp_visible_q[$];     // predicted o_visible, oldest first
    t_cull_req cur_req;              // transaction currently on the bus

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_queued     = 0;
    int n_tests      = 0;
    int n_visible    = 0;
    int n_loads      = 0;
    int n_fail       = 0;
    int idle_cycles  = 0;

    initial begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            pl_nx[p]  = '0;
            pl_ny[p]  = '0;
            pl_nz[p]  = '0;
            pl_ofs[p] = '0;
        end
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Classify the chunk box against every stored plane. Everything is exact
    // in Q.30: center times normal, offset shifted up by 14.
    function automatic logic box_visible(input logic [CRD_W-1:0] x, y, z);
        longint cx, cy, cz, nx, ny, nz, rad, sdist;
        logic   vis;
        cx  = longint'($signed(x)) + HALF_Q16;
        cy  = longint'($signed(y)) + HALF_Q16;
        cz  = longint'($signed(z)) + HALF_Q16;
        vis = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            nx    = longint'($signed(pl_nx[p]));
            ny    = longint'($signed(pl_ny[p]));
            nz    = longint'($signed(pl_nz[p]));
            rad   = HALF_Q16 * (mag(nx) + mag(ny) + mag(nz));
            sdist = cx * nx + cy * ny + cz * nz - longint'($signed(pl_ofs[p])) * 16384;
            // a zero plane gives rad == sdist == 0 and never rejects
            if (reject_pos ? (sdist > rad) : (sdist < -rad))
                vis = 1'b0;
        end
        return vis;
    endfunction

    // Apply one accepted transaction to the shadow state
    task automatic apply_cull_req(input t_cull_req r);
        logic v;
        if (r.op == OP_LOAD) begin
            // slots 6 and 7 do not exist, load is dropped
            if (r.pidx < PLANE_COUNT) begin
                pl_nx[r.pidx]  = r.nx;
                pl_ny[r.pidx]  = r.ny;
                pl_nz[r.pidx]  = r.nz;
                pl_ofs[r.pidx] = r.ofs;
                n_loads++;
            end
        end else begin
            v = box_visible(r.cx, r.cy, r.cz);
            exp_visible_q.push_back(v);
            n_tests++;
            if (v)
                n_visible++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    task automatic push_req(input t_cull_req r);
        cull_req_q.push_back(r);
        if (!(r.op == OP_LOAD && r.pidx >= PLANE_COUNT))
            n_queued++;
    endtask

    // Load transaction; chunk fields carry junk that must be ignored
    task automatic push_load(input int pidx, input longint nx, ny, nz, ofs);
        t_cull_req r;
        r.op   = OP_LOAD;
        r.pidx = PIDX_W'(pidx);
        r.nx   = NRM_W'(nx);
        r.ny   = NRM_W'(ny);
        r.nz   = NRM_W'(nz);
        r.ofs  = OFS_W'(ofs);
        r.cx   = $urandom;
        r.cy   = $urandom;
        r.cz   = $urandom;
        push_req(r);
    endtask

    // Test transaction; plane fields carry junk that must be ignored
    task automatic push_test(input longint x, y, z);
        t_cull_req r;
        r.op   = OP_TEST;
        r.pidx = PIDX_W'($urandom_range(7));
        r.nx   = NRM_W'($urandom);
        r.ny   = NRM_W'($urandom);
        r.nz   = NRM_W'($urandom);
        r.ofs  = $urandom;
        r.cx   = CRD_W'(x);
        r.cy   = CRD_W'(y);
        r.cz   = CRD_W'(z);
        push_req(r);
    endtask

    // Six axis-aligned planes (with slight tilt) bounding a random box, then
    // a burst of chunk tests scattered around it. Normals face inward when
    // the negative side rejects and outward when the positive side does.
    task automatic queue_frustum();
        longint lo[3], hi[3], nrm[3];
        longint ctr, w, span, ofs, base;
        longint pt[3];
        int     a, p, k;
        for (a = 0; a < 3; a++) begin
            ctr   = longint'($urandom_range(32'h2000_0000)) - 64'sh1000_0000;
            w     = longint'($urandom_range(32'h0080_0000)) + 65536;
            lo[a] = ctr - w;
            hi[a] = ctr + w;
        end
        k = $urandom_range(PLANE_COUNT - 1);
        for (int n = 0; n < PLANE_COUNT; n++) begin
            p = (n + k) % PLANE_COUNT;
            a = p / 2;
            for (int i = 0; i < 3; i++)
                nrm[i] = ($urandom_range(3) == 0) ? 0 : longint'($urandom_range(32)) - 16;
            if (p % 2 == 0) begin
                nrm[a] = Q_ONE;
                ofs    = lo[a];
            end else begin
                nrm[a] = -Q_ONE;
                ofs    = -hi[a];
            end
            if (reject_pos) begin
                for (int i = 0; i < 3; i++)
                    nrm[i] = -nrm[i];
                ofs = -ofs;
            end
            // now and then leave a face open
            if ($urandom_range(15) == 0) begin
                nrm = '{0, 0, 0};
                ofs = 0;
            end
            push_load(p, nrm[0], nrm[1], nrm[2], ofs);
            if ($urandom_range(19) == 0)
                push_load(PLANE_COUNT + $urandom_range(1), longint'($urandom),
                          longint'($urandom), longint'($urandom), longint'($urandom));
        end
        repeat (4 + $urandom_range(8)) begin
            for (a = 0; a < 3; a++) begin
                span  = (hi[a] - lo[a]) / 8;
                base  = lo[a] - 4 * HALF_Q16 - span;
                pt[a] = base + longint'($urandom_range(32'(hi[a] + 2 * HALF_Q16 + span - base)));
            end
            push_test(pt[0], pt[1], pt[2]);
        end
    endtask

    // Raw full-range transactions, every bit free
    task automatic queue_noise();
        t_cull_req r;
        repeat (1 + $urandom_range(5)) begin
            r.op   = 1'($urandom_range(1));
            r.pidx = PIDX_W'($urandom_range(7));
            r.nx   = NRM_W'($urandom);
            r.ny   = NRM_W'($urandom);
            r.nz   = NRM_W'($urandom);
            r.ofs  = $urandom;
            r.cx   = $urandom;
            r.cy   = $urandom;
            r.cz   = $urandom;
            push_req(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: one transaction per handshake, random gaps on the sender side
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                apply_cull_req(cur_req);
            // payload may only move when nothing is stalled on the bus
            if (!in_valid || !in_stall) begin
                if (cull_req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_req      = cull_req_q.pop_front();
                    in_valid     <= 1'b1;
                    opcode       <= cur_req.op;
                    plane_index  <= cur_req.pidx;
                    normal_x     <= cur_req.nx;
                    normal_y     <= cur_req.ny;
                    normal_z     <= cur_req.nz;
                    plane_offset <= cur_req.ofs;
                    chunk_x      <= cur_req.cx;
                    chunk_y      <= cur_req.cy;
                    chunk_z      <= cur_req.cz;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random back-pressure, compare each result with the oldest
    // prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        logic exp_vis;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (exp_visible_q.size() == 0) begin
                    $error("visible: result with nothing pending, got %0b", visible);
                    n_fail++;
                end else begin
                    exp_vis = exp_visible_q.pop_front();
                    if (visible !== exp_vis) begin
                        $error("visible mismatch: expected %0b, got %0b", exp_vis, visible);
                        n_fail++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < snk_idle_pct);
        end
    end

    // Watchdog: counts cycles with no transaction on any port
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------

    // Sender holds off until everything in flight has come out, plus margin
    // for a trailing load that gives no result.
    task automatic settle();
        do
            @(negedge clk);
        while (cull_req_q.size() != 0 || in_valid || exp_visible_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write, setup then access, then read back; only called while the
    // block is idle
    task automatic write_reject_side(input logic side);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REJECT_SIDE_ADDR;
        pwdata  <= APB_DATA_W'(side);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reject_pos = side;
        @(negedge clk);
        if (prdata !== APB_DATA_W'(side)) begin
            $error("prdata: expected %0h, got %0h", APB_DATA_W'(side), prdata);
            n_fail++;
        end
        if (pready !== 1'b1) begin
            $error("pready: expected 1, got %0b", pready);
            n_fail++;
        end
    endtask

    task automatic run_random(input logic side, input int src_pct, input int snk_pct);
        int target;
        write_reject_side(side);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        target       = n_queued + PHASE_ITEMS;
        while (n_queued < target) begin
            if ($urandom_range(9) < 8)
                queue_frustum();
            else
                queue_noise();
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reject_side still at its reset value (negative side)
        src_idle_pct = 23;
        snk_idle_pct = 73;
        // planes still at reset never reject, even at the coordinate extremes
        push_test(0, 0, 0);
        push_test(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        push_test(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        // loads to slots 6 and 7 must be dropped
        push_load(6, Q_ONE, 0, 0, 64'sh7FFF_FFFF);
        push_load(7, Q_ONE, Q_ONE, Q_ONE, 64'sh7FFF_FFFF);
        push_test(-64'sh8000_0000, 0, 0);
        // x = 0 plane: touching on either side straddles, one LSB past rejects
        push_load(0, Q_ONE, 0, 0, 0);
        push_test(0, 0, 0);
        push_test(-2 * HALF_Q16, 0, 0);
        push_test(-2 * HALF_Q16 - 1, 0, 0);
        // normal and offset extremes in the other slots
        push_load(1, -32768, -32768, -32768, -64'sh8000_0000);
        push_load(2, 32767, 32767, 32767, 64'sh7FFF_FFFF);
        push_load(3, 0, -32768, 0, 0);
        push_load(4, 0, 0, 32767, -64'sh8000_0000);
        push_load(5, 1, -1, 1, -65536);
        push_test(0, 0, 0);
        push_test(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        push_test(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        push_test(64'sh7FFF_FFFF, -64'sh8000_0000, 0);
        push_test(HALF_Q16, -HALF_Q16, 12345);
        // clear slot 0 back to a zero plane
        push_load(0, 0, 0, 0, 0);
        push_test(-2 * HALF_Q16 - 1, 0, 0);
        settle();

        // Random phases: sender-light/receiver-heavy, the reverse, then none
        run_random(1'b1, 23, 73);
        run_random(1'b0, 73, 23);
        run_random(1'b1, 0, 0);

        $display("Ran %0d chunk tests (%0d visible, %0d culled) and %0d plane loads,",
                 n_tests, n_visible, n_tests - n_visible, n_loads);
        $display("under both reject sides and three back-pressure mixes.");
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
src/aff_pkg.sv
src/aff_plane_store.sv
src/aff_plane_lane.sv
src/aabb_frustum_cull.sv
sim/tb_top.sv
